// ----- hw/rtl/gb18030_text_statistics_counter_assert.svh -----
// Assertion macros shared by the text statistics counter RTL.
// Depends on nothing; included by the modules that carry checks.
`ifndef GB18030_TEXT_STATISTICS_COUNTER_ASSERT_SVH
`define GB18030_TEXT_STATISTICS_COUNTER_ASSERT_SVH

// Same-cycle implication, held off during reset
`define GTSC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, held off during reset
`define GTSC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/gtsc_pkg.sv -----
// Shared types, constants and helpers of the GB18030 text statistics counter.
// No dependencies.
package gtsc_pkg;

   // Sizes
   localparam int PATTERN_MAX = 8;
   localparam int COUNT_WIDTH = 32;
   localparam int OUT_WIDTH   = 32;
   localparam int BYTE_WIDTH  = 8;
   localparam int PLEN_WIDTH  = 4;
   localparam int PAT_WIDTH   = BYTE_WIDTH * PATTERN_MAX;
   localparam int NUM_TOTALS  = 7;
   localparam int SAT_WIDTH   = (COUNT_WIDTH > OUT_WIDTH) ? COUNT_WIDTH : OUT_WIDTH;

   // Total indexes
   localparam int T_OCC     = 0;
   localparam int T_WORD    = 1;
   localparam int T_CHAR    = 2;
   localparam int T_CHAR_SP = 3;
   localparam int T_PARA    = 4;
   localparam int T_LINE    = 5;
   localparam int T_NONCH   = 6;

   // Byte codes
   localparam logic [BYTE_WIDTH-1:0] NUL_BYTE   = 8'h00;
   localparam logic [BYTE_WIDTH-1:0] LINE_FEED  = 8'h0A;
   localparam logic [BYTE_WIDTH-1:0] TAB_BYTE   = 8'd9;
   localparam logic [BYTE_WIDTH-1:0] SPACE_BYTE = 8'd32;
   localparam logic [BYTE_WIDTH-1:0] PRINT_LO   = 8'd33;
   localparam logic [BYTE_WIDTH-1:0] PRINT_HI   = 8'd126;
   localparam logic [BYTE_WIDTH-1:0] LEAD_LO    = 8'h81;
   localparam logic [BYTE_WIDTH-1:0] LEAD_HI    = 8'hFE;
   localparam logic [BYTE_WIDTH-1:0] TRAIL_LO   = 8'h40;
   localparam logic [BYTE_WIDTH-1:0] TRAIL_MID  = 8'h7E;
   localparam logic [BYTE_WIDTH-1:0] TRAIL_UP   = 8'h80;
   localparam logic [BYTE_WIDTH-1:0] DIGIT_LO   = 8'h30;
   localparam logic [BYTE_WIDTH-1:0] DIGIT_HI   = 8'h39;

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
   localparam logic [OUT_WIDTH-1:0]   OUT_MAX = {OUT_WIDTH{1'b1}};

   // Per-byte control for the match cells
   typedef struct packed {
      logic advance;  // item transfer this cycle
      logic step;     // byte takes part in matching (not NUL)
      logic clear;    // line end or full match
   } match_ctrl_type;

   // Counter bumps from the classifier
   typedef struct packed {
      logic word;
      logic char_ns;
      logic char_sp;
      logic para;
      logic line;
      logic nonch;
   } class_inc_type;

   // Clamp a counter to the output width
   function automatic logic [OUT_WIDTH-1:0] sat_out(input logic [COUNT_WIDTH-1:0] value);
      logic [SAT_WIDTH-1:0] wide;
      wide = SAT_WIDTH'(value);
      if (wide > SAT_WIDTH'(OUT_MAX)) begin
         return OUT_MAX;
      end
      return OUT_WIDTH'(wide);
   endfunction

endpackage

// ----- hw/rtl/gtsc_match_cell.sv -----
// One cell of the pattern match chain: holds one partial-match bit.
// Depends on gtsc_pkg.
module gtsc_match_cell
   import gtsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  match_ctrl_type        ctrl,
   input  logic [BYTE_WIDTH-1:0] text_byte,
   input  logic [BYTE_WIDTH-1:0] pattern_byte,
   input  logic                  prev_hit,   // neighbor matched up to here
   input  logic                  active,     // cell lies within pattern length
   input  logic                  keep,       // cell is not the final position
   output logic                  hit,
   output logic                  state
);

   logic state_ff;
   logic state_in;

   // Extend the neighbor's prefix by this byte
   assign hit = ctrl.step & active & prev_hit & (pattern_byte == text_byte);

   always_comb begin
      state_in = state_ff;
      if (ctrl.advance) begin
         if (ctrl.clear) begin
            state_in = 1'b0;
         end else if (ctrl.step) begin
            state_in = keep & hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
      end
   end

   assign state = state_ff;

endmodule

// ----- hw/rtl/gtsc_classifier.sv -----
// Byte classifier: word, character, line and GB18030 sequence tracking.
// Depends on gtsc_pkg and the assertion macro header.
`include "gb18030_text_statistics_counter_assert.svh"
module gtsc_classifier
   import gtsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [BYTE_WIDTH-1:0] text_byte,
   input  logic                  last_byte,
   output class_inc_type         inc
);

   typedef enum logic [1:0] {
      PH_NONE,
      PH_LEAD,
      PH_DIGIT,
      PH_LEAD2
   } phase_type;

   phase_type phase_ff, phase_in;
   logic      in_word_ff, in_word_in;
   logic      content_ff, content_in;

   logic is_nul, is_lf, line_end, is_lead, is_digit, is_trail, is_print, is_blank;

   assign is_nul   = (text_byte == NUL_BYTE);
   assign is_lf    = (text_byte == LINE_FEED);
   assign line_end = is_lf | last_byte;
   assign is_lead  = text_byte inside {[LEAD_LO:LEAD_HI]};
   assign is_digit = text_byte inside {[DIGIT_LO:DIGIT_HI]};
   assign is_trail = text_byte inside {[TRAIL_LO:TRAIL_MID], [TRAIL_UP:LEAD_HI]};
   assign is_print = text_byte inside {[PRINT_LO:PRINT_HI]};
   assign is_blank = text_byte inside {SPACE_BYTE, TAB_BYTE};

   // Next state and counter bumps for one byte
   always_comb begin
      phase_in   = phase_ff;
      in_word_in = in_word_ff;
      content_in = content_ff;
      inc        = '0;
      if (!is_nul && !is_lf) begin
         case (phase_ff)
            PH_NONE: begin
               if (is_blank) begin
                  if (in_word_in) begin
                     inc.word  = 1'b1;
                     inc.nonch = 1'b1;
                  end
                  in_word_in  = 1'b0;
                  inc.char_sp = 1'b1;
               end else if (is_print) begin
                  content_in  = 1'b1;
                  in_word_in  = 1'b1;
                  inc.char_ns = 1'b1;
                  inc.char_sp = 1'b1;
               end else if (is_lead) begin
                  if (in_word_in) begin
                     inc.word  = 1'b1;
                     inc.nonch = 1'b1;
                  end
                  in_word_in  = 1'b0;
                  content_in  = 1'b1;
                  inc.char_ns = 1'b1;
                  inc.char_sp = 1'b1;
                  phase_in    = PH_LEAD;
               end
            end
            PH_LEAD: begin
               if (is_trail) begin
                  inc.word = 1'b1;
                  phase_in = PH_NONE;
               end else if (is_digit) begin
                  phase_in = PH_DIGIT;
               end else begin
                  phase_in = PH_NONE;
               end
            end
            PH_DIGIT: begin
               phase_in = is_lead ? PH_LEAD2 : PH_NONE;
            end
            PH_LEAD2: begin
               inc.word = is_digit;
               phase_in = PH_NONE;
            end
            default: begin
               phase_in = PH_NONE;
            end
         endcase
      end
      // Line end closes the word, the paragraph and any pending sequence
      if (line_end) begin
         if (in_word_in) begin
            inc.word  = 1'b1;
            inc.nonch = 1'b1;
         end
         inc.para   = content_in;
         inc.line   = 1'b1;
         in_word_in = 1'b0;
         content_in = 1'b0;
         phase_in   = PH_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_NONE;
         in_word_ff <= 1'b0;
         content_ff <= 1'b0;
      end else if (advance) begin
         phase_ff   <= phase_in;
         in_word_ff <= in_word_in;
         content_ff <= content_in;
      end
   end

   // A pending sequence always started with a lead byte on this line
   `GTSC_ASSERT_IMP(a_phase_has_content, clock, reset, phase_ff != PH_NONE, content_ff, "sequence pending on a line without content")
   // Inside a sequence no ASCII word is open
   `GTSC_ASSERT_IMP(a_phase_no_word, clock, reset, phase_ff != PH_NONE, !in_word_ff, "open word during multibyte sequence")
   // A line end leaves the line state clear
   `GTSC_ASSERT_NXT(a_line_end_clear, clock, reset, advance && line_end, !content_ff && !in_word_ff && phase_ff == PH_NONE, "line state not cleared at line end")

endmodule

// ----- hw/rtl/gb18030_text_statistics_counter.sv -----
// Top level of the GB18030 text statistics counter: APB register port,
// match cell chain, classifier, saturating totals, result register.
// Depends on gtsc_pkg, gtsc_match_cell, gtsc_classifier and the macro header.
// Throughput: one byte per cycle while req_stall is low; each byte is fully handled in the cycle it transfers.
// The totals appear on rsp in the cycle after the transfer of the last byte.
// Only a last byte is held off, and only while a previous result is stalled at the output.
// Reset (synchronous): clears all totals, line state, match cells and result valid;
// pattern_bytes resets to 0 and pattern_length to 1.
`include "gb18030_text_statistics_counter_assert.svh"
module gb18030_text_statistics_counter
   import gtsc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // byte input
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [BYTE_WIDTH-1:0] req_text_byte,
   input  logic                  req_last_byte,
   // totals output
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [OUT_WIDTH-1:0]  rsp_occurrence_count,
   output logic [OUT_WIDTH-1:0]  rsp_total_words,
   output logic [OUT_WIDTH-1:0]  rsp_char_count_no_space,
   output logic [OUT_WIDTH-1:0]  rsp_char_count_with_space,
   output logic [OUT_WIDTH-1:0]  rsp_paragraph_count,
   output logic [OUT_WIDTH-1:0]  rsp_total_lines,
   output logic [OUT_WIDTH-1:0]  rsp_non_chinese_words,
   // register port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [3:0]            csr_paddr,
   input  logic [PAT_WIDTH-1:0]  csr_pwdata,
   output logic [PAT_WIDTH-1:0]  csr_prdata,
   output logic                  csr_pready
);

   localparam logic CSR_PATTERN_BYTES  = 1'b0;
   localparam logic CSR_PATTERN_LENGTH = 1'b1;

   // ---------------- register port ----------------
   logic [PAT_WIDTH-1:0]  pattern_ff;
   logic [PLEN_WIDTH-1:0] plen_ff;
   logic                  csr_write;
   logic                  csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = csr_paddr[3];

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         plen_ff    <= PLEN_WIDTH'(1);
      end else if (csr_write) begin
         case (csr_index)
            CSR_PATTERN_BYTES:  pattern_ff <= csr_pwdata;
            CSR_PATTERN_LENGTH: plen_ff    <= csr_pwdata[PLEN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_PATTERN_BYTES:  csr_prdata = pattern_ff;
         CSR_PATTERN_LENGTH: csr_prdata = PAT_WIDTH'(plen_ff);
         default:            csr_prdata = '0;
      endcase
   end

   // ---------------- handshake ----------------
   logic req_fire;
   logic rsp_valid_ff;
   logic line_end;

   assign req_stall = rsp_valid_ff & rsp_stall & req_last_byte;
   assign req_fire  = req_valid & ~req_stall;
   assign line_end  = (req_text_byte == LINE_FEED) | req_last_byte;

   // ---------------- match chain ----------------
   logic [PLEN_WIDTH-1:0]  eff_len;
   logic [PATTERN_MAX-1:0] match_hit;
   logic [PATTERN_MAX-1:0] match_state;
   logic [PATTERN_MAX-1:0] cell_prev;
   logic [PATTERN_MAX-1:0] cell_active;
   logic [PATTERN_MAX-1:0] cell_keep;
   logic [PATTERN_MAX-1:0] cell_last;
   logic                   full_match;
   match_ctrl_type         mctrl;

   // Length 0 acts as 1, oversize as the maximum
   always_comb begin
      if (plen_ff == '0) begin
         eff_len = PLEN_WIDTH'(1);
      end else if (plen_ff > PLEN_WIDTH'(PATTERN_MAX)) begin
         eff_len = PLEN_WIDTH'(PATTERN_MAX);
      end else begin
         eff_len = plen_ff;
      end
   end

   assign full_match    = |(match_hit & cell_last);
   assign mctrl.advance = req_fire;
   assign mctrl.step    = (req_text_byte != NUL_BYTE);
   assign mctrl.clear   = line_end | full_match;

   for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
      if (k == 0) begin : g_head
         assign cell_prev[k] = 1'b1;
      end else begin : g_body
         assign cell_prev[k] = match_state[k-1];
      end
      assign cell_active[k] = (PLEN_WIDTH'(k) < eff_len);
      assign cell_keep[k]   = (PLEN_WIDTH'(k + 1) < eff_len);
      assign cell_last[k]   = (PLEN_WIDTH'(k + 1) == eff_len);

      gtsc_match_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctrl         (mctrl),
         .text_byte    (req_text_byte),
         .pattern_byte (pattern_ff[k*BYTE_WIDTH +: BYTE_WIDTH]),
         .prev_hit     (cell_prev[k]),
         .active       (cell_active[k]),
         .keep         (cell_keep[k]),
         .hit          (match_hit[k]),
         .state        (match_state[k])
      );
   end

   // ---------------- classifier ----------------
   class_inc_type cinc;

   gtsc_classifier u_classifier (
      .clock     (clock),
      .reset     (reset),
      .advance   (req_fire),
      .text_byte (req_text_byte),
      .last_byte (req_last_byte),
      .inc       (cinc)
   );

   // ---------------- totals ----------------
   logic [NUM_TOTALS-1:0]  bump;
   logic [COUNT_WIDTH-1:0] count_ff [NUM_TOTALS];
   logic [COUNT_WIDTH-1:0] count_in [NUM_TOTALS];
   logic [OUT_WIDTH-1:0]   out_ff   [NUM_TOTALS];

   always_comb begin
      bump            = '0;
      bump[T_OCC]     = full_match;
      bump[T_WORD]    = cinc.word;
      bump[T_CHAR]    = cinc.char_ns;
      bump[T_CHAR_SP] = cinc.char_sp;
      bump[T_PARA]    = cinc.para;
      bump[T_LINE]    = cinc.line;
      bump[T_NONCH]   = cinc.nonch;
   end

   for (genvar i = 0; i < NUM_TOTALS; i++) begin : g_total
      // Saturating increment
      assign count_in[i] = (bump[i] && count_ff[i] != CNT_MAX) ?
                           count_ff[i] + COUNT_WIDTH'(1) : count_ff[i];

      always_ff @(posedge clock) begin
         if (reset) begin
            count_ff[i] <= '0;
         end else if (req_fire) begin
            count_ff[i] <= req_last_byte ? '0 : count_in[i];
         end
      end

      // Result register, loaded on the last byte
      always_ff @(posedge clock) begin
         if (req_fire && req_last_byte) begin
            out_ff[i] <= sat_out(count_in[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire && req_last_byte) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid                 = rsp_valid_ff;
   assign rsp_occurrence_count      = out_ff[T_OCC];
   assign rsp_total_words           = out_ff[T_WORD];
   assign rsp_char_count_no_space   = out_ff[T_CHAR];
   assign rsp_char_count_with_space = out_ff[T_CHAR_SP];
   assign rsp_paragraph_count       = out_ff[T_PARA];
   assign rsp_total_lines           = out_ff[T_LINE];
   assign rsp_non_chinese_words     = out_ff[T_NONCH];

   // The final pattern position never holds a partial match
   `GTSC_ASSERT_IMP(a_tail_cell_idle, clock, reset, 1'b1, !match_state[PATTERN_MAX-1], "tail set")
   // A line end clears every partial match
   `GTSC_ASSERT_NXT(a_line_end_match_clear, clock, reset, req_fire && line_end, match_state == '0, "match kept")
   // The last byte produces a result with at least one line and clears the totals
   `GTSC_ASSERT_NXT(a_last_result, clock, reset, req_fire && req_last_byte, rsp_valid_ff && rsp_total_lines != '0 && count_ff[T_LINE] == '0, "no totals")

endmodule

// ----- test/gtsc_checker.sv -----
// Checker for the GB18030 text statistics counter: follows the byte and totals
// transfers and the register port, predicts each set of totals and compares it.
// Depends on gtsc_pkg.
module gtsc_checker
   import gtsc_pkg::*;
#(
   parameter logic [3:0] ADDR_PATTERN = 4'h0,
   parameter logic [3:0] ADDR_LENGTH  = 4'h8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [BYTE_WIDTH-1:0] req_text_byte,
   input  logic                  req_last_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [OUT_WIDTH-1:0]  rsp_occurrence_count,
   input  logic [OUT_WIDTH-1:0]  rsp_total_words,
   input  logic [OUT_WIDTH-1:0]  rsp_char_count_no_space,
   input  logic [OUT_WIDTH-1:0]  rsp_char_count_with_space,
   input  logic [OUT_WIDTH-1:0]  rsp_paragraph_count,
   input  logic [OUT_WIDTH-1:0]  rsp_total_lines,
   input  logic [OUT_WIDTH-1:0]  rsp_non_chinese_words,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic                  csr_pready,
   input  logic [3:0]            csr_paddr,
   input  logic [PAT_WIDTH-1:0]  csr_pwdata,
   output int                    error_count,
   output int                    pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [NUM_TOTALS-1:0][OUT_WIDTH-1:0] totals_vec_type;
   typedef enum logic [1:0] {SEQ_NONE, SEQ_LEAD, SEQ_DIGIT, SEQ_LEAD2} seq_phase_type;

   // Predictor state
   logic [PAT_WIDTH-1:0]    pat_bytes;
   logic [PLEN_WIDTH-1:0]   pat_len;
   logic                    in_word;
   logic                    line_has_text;
   seq_phase_type           seq_phase;
   logic [PATTERN_MAX-2:0]  partial_bits;
   logic [COUNT_WIDTH-1:0]  totals [NUM_TOTALS];

   totals_vec_type expected_totals [$];
   string          field_name [NUM_TOTALS];
   int             fail_total = 0;
   int             queued = 0;

   assign error_count   = fail_total;
   assign pending_count = queued;

   initial begin
      field_name[T_OCC]     = "occurrence_count";
      field_name[T_WORD]    = "total_words";
      field_name[T_CHAR]    = "char_count_no_space";
      field_name[T_CHAR_SP] = "char_count_with_space";
      field_name[T_PARA]    = "paragraph_count";
      field_name[T_LINE]    = "total_lines";
      field_name[T_NONCH]   = "non_chinese_words";
   end

   function automatic void flag(input string what);
      if (fail_total < 10) begin
         $display("%s", what);
      end
      fail_total++;
   endfunction

   function automatic logic in_range(input logic [7:0] b, lo, hi);
      return (b >= lo) && (b <= hi);
   endfunction

   // Saturating count
   function automatic void bump(input int k);
      if (totals[k] != CNT_MAX) begin
         totals[k] = totals[k] + COUNT_WIDTH'(1);
      end
   endfunction

   function automatic void close_word();
      if (in_word) begin
         bump(T_WORD);
         bump(T_NONCH);
         in_word = 1'b0;
      end
   endfunction

   // Non-overlapping pattern search; bit k of partial_bits: bytes 0..k seen
   function automatic void match_byte(input logic [7:0] b);
      int                     eff_len;
      int                     k;
      logic [PATTERN_MAX-1:0] prev;
      logic [PATTERN_MAX-1:0] hit;
      eff_len = (pat_len == 0) ? 1 : (pat_len > PATTERN_MAX) ? PATTERN_MAX : int'(pat_len);
      prev = {partial_bits, 1'b1};
      hit = '0;
      for (k = 0; k < eff_len; k++) begin
         if (prev[k] && pat_bytes[8*k +: 8] == b) begin
            hit[k] = 1'b1;
         end
      end
      if (hit[eff_len-1]) begin
         bump(T_OCC);
         partial_bits = '0;
      end else begin
         partial_bits = '0;
         for (k = 0; k < eff_len - 1; k++) begin
            partial_bits[k] = hit[k];
         end
      end
   endfunction

   // Byte inside a pending multibyte character
   function automatic void sequence_byte(input logic [7:0] b);
      case (seq_phase)
         SEQ_LEAD: begin
            if (in_range(b, TRAIL_LO, TRAIL_MID) || in_range(b, TRAIL_UP, LEAD_HI)) begin
               bump(T_WORD);
               seq_phase = SEQ_NONE;
            end else if (in_range(b, DIGIT_LO, DIGIT_HI)) begin
               seq_phase = SEQ_DIGIT;
            end else begin
               seq_phase = SEQ_NONE;
            end
         end
         SEQ_DIGIT: begin
            seq_phase = in_range(b, LEAD_LO, LEAD_HI) ? SEQ_LEAD2 : SEQ_NONE;
         end
         default: begin
            if (in_range(b, DIGIT_LO, DIGIT_HI)) begin
               bump(T_WORD);
            end
            seq_phase = SEQ_NONE;
         end
      endcase
   endfunction

   // Byte outside any sequence; controls, 0x7F, 0x80 and 0xFF fall through
   function automatic void classify_byte(input logic [7:0] b);
      if (b == SPACE_BYTE || b == TAB_BYTE) begin
         close_word();
         bump(T_CHAR_SP);
      end else if (in_range(b, PRINT_LO, PRINT_HI)) begin
         line_has_text = 1'b1;
         in_word = 1'b1;
         bump(T_CHAR);
         bump(T_CHAR_SP);
      end else if (in_range(b, LEAD_LO, LEAD_HI)) begin
         line_has_text = 1'b1;
         close_word();
         bump(T_CHAR);
         bump(T_CHAR_SP);
         seq_phase = SEQ_LEAD;
      end
   endfunction

   function automatic void take_byte(input logic [7:0] b, input logic last);
      totals_vec_type snap;
      int             k;
      if (b != NUL_BYTE) begin
         match_byte(b);
         if (b != LINE_FEED) begin
            if (seq_phase != SEQ_NONE) begin
               sequence_byte(b);
            end else begin
               classify_byte(b);
            end
         end
      end
      // Line end, by line feed or last byte
      if (b == LINE_FEED || last) begin
         close_word();
         if (line_has_text) begin
            bump(T_PARA);
         end
         bump(T_LINE);
         line_has_text = 1'b0;
         seq_phase = SEQ_NONE;
         partial_bits = '0;
      end
      if (last) begin
         for (k = 0; k < NUM_TOTALS; k++) begin
            snap[k] = (totals[k] > OUT_MAX) ? OUT_MAX : OUT_WIDTH'(totals[k]);
            totals[k] = '0;
         end
         expected_totals.push_back(snap);
      end
   endfunction

   always @(posedge clock) begin : watch
      totals_vec_type seen;
      totals_vec_type want;
      int             k;
      if (reset) begin
         pat_bytes = '0;
         pat_len = PLEN_WIDTH'(1);
         in_word = 1'b0;
         line_has_text = 1'b0;
         seq_phase = SEQ_NONE;
         partial_bits = '0;
         for (k = 0; k < NUM_TOTALS; k++) begin
            totals[k] = '0;
         end
         expected_totals.delete();
      end else begin
         // Register writes do not touch the running state
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr == ADDR_PATTERN) begin
               pat_bytes = csr_pwdata;
            end else if (csr_paddr == ADDR_LENGTH) begin
               pat_len = csr_pwdata[PLEN_WIDTH-1:0];
            end
         end
         // Totals transfer
         if (rsp_valid && !rsp_stall) begin
            seen[T_OCC]     = rsp_occurrence_count;
            seen[T_WORD]    = rsp_total_words;
            seen[T_CHAR]    = rsp_char_count_no_space;
            seen[T_CHAR_SP] = rsp_char_count_with_space;
            seen[T_PARA]    = rsp_paragraph_count;
            seen[T_LINE]    = rsp_total_lines;
            seen[T_NONCH]   = rsp_non_chinese_words;
            if (expected_totals.size() == 0) begin
               flag($sformatf("unexpected totals at %0t: words %0d lines %0d",
                              $realtime, seen[T_WORD], seen[T_LINE]));
            end else begin
               want = expected_totals.pop_front();
               for (k = 0; k < NUM_TOTALS; k++) begin
                  if (seen[k] !== want[k]) begin
                     flag($sformatf("mismatch %s at %0t: expected %0d, got %0d",
                                    field_name[k], $realtime, want[k], seen[k]));
                  end
               end
            end
         end
         // Byte transfer
         if (req_valid && !req_stall) begin
            take_byte(req_text_byte, req_last_byte);
         end
      end
      queued = expected_totals.size();
   end

endmodule

// ----- test/tb.sv -----
// Testbench top of the GB18030 text statistics counter: clock, reset, register
// writes, byte stimulus with idling and back-pressure, and the verdict.
// Depends on gtsc_pkg, the counter RTL and gtsc_checker.
module tb;
   import gtsc_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] ADDR_PATTERN   = 4'h0;
   localparam logic [3:0] ADDR_LENGTH    = 4'h8;
   localparam int         HOLD_CYCLES    = 300;
   localparam int         SETTLE_CYCLES  = 4;
   localparam int         RANDOM_PHASES  = 8;
   localparam int         BYTES_PER_PHASE = 170;
   localparam int         LIMIT_NS       = 1_000_000;

   // Idling modes, cycled through the random phases
   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [BYTE_WIDTH-1:0] req_text_byte = '0;
   logic                  req_last_byte = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [OUT_WIDTH-1:0]  rsp_occurrence_count;
   logic [OUT_WIDTH-1:0]  rsp_total_words;
   logic [OUT_WIDTH-1:0]  rsp_char_count_no_space;
   logic [OUT_WIDTH-1:0]  rsp_char_count_with_space;
   logic [OUT_WIDTH-1:0]  rsp_paragraph_count;
   logic [OUT_WIDTH-1:0]  rsp_total_lines;
   logic [OUT_WIDTH-1:0]  rsp_non_chinese_words;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [3:0]            csr_paddr = '0;
   logic [PAT_WIDTH-1:0]  csr_pwdata = '0;
   logic [PAT_WIDTH-1:0]  csr_prdata;
   logic                  csr_pready;
   int                    error_count;
   int                    pending_count;

   int unsigned idle_pct = 0;
   int unsigned stall_pct = 0;
   logic        want_hold = 1'b0;
   int          held_cycles = 0;
   logic [7:0]  text_q [$];

   gb18030_text_statistics_counter u_dut (.*);

   gtsc_checker #(
      .ADDR_PATTERN (ADDR_PATTERN),
      .ADDR_LENGTH  (ADDR_LENGTH)
   ) u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Receiver: one long hold-off on request, else random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (want_hold && held_cycles < HOLD_CYCLES) begin
         rsp_stall <= 1'b1;
         held_cycles++;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   initial begin
      #(LIMIT_NS);
      $display("TB_ERROR");
      $finish;
   end

   task automatic write_reg(input logic [3:0] addr, input logic [PAT_WIDTH-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic set_idling(input idle_mode_type mode);
      idle_pct  = (mode == IDLE_SENDER) ? 53 : (mode == IDLE_BOTH) ? 27 : 0;
      stall_pct = (mode == IDLE_RECEIVER) ? 53 : (mode == IDLE_BOTH) ? 27 : 0;
   endtask

   // One byte transfer, with random idle cycles ahead of it
   task automatic send_byte(input logic [7:0] b, input logic last);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_text_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_text();
      int i;
      for (i = 0; i < text_q.size(); i++) begin
         send_byte(text_q[i], i == text_q.size() - 1);
      end
      text_q.delete();
   endtask

   // Stop sending until every set of totals is back, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [7:0] letter();
      return 8'h61 + 8'($urandom_range(0, 2));  // 'a'..'c'
   endfunction

   function automatic logic [7:0] pattern_byte();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) return 8'h61;
      if (pick < 7) return 8'h62;
      if (pick < 8) return 8'h63;
      if (pick < 9) return LINE_FEED;
      return SPACE_BYTE;
   endfunction

   function automatic logic [7:0] lead_byte();
      return 8'($urandom_range(LEAD_LO, LEAD_HI));
   endfunction

   function automatic logic [7:0] digit_byte();
      return 8'($urandom_range(DIGIT_LO, DIGIT_HI));
   endfunction

   // Mostly well-formed pieces of text, some broken sequences and noise
   task automatic add_token();
      int kind;
      int n;
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
         n = $urandom_range(1, 5);
         repeat (n) begin
            text_q.push_back(($urandom_range(0, 3) == 0) ?
                             8'($urandom_range(PRINT_LO, PRINT_HI)) : letter());
         end
      end else if (kind < 45) begin
         text_q.push_back($urandom_range(0, 1) ? SPACE_BYTE : TAB_BYTE);
      end else if (kind < 55) begin
         text_q.push_back(LINE_FEED);
      end else if (kind < 67) begin
         text_q.push_back(lead_byte());
         text_q.push_back($urandom_range(0, 1) ? 8'($urandom_range(TRAIL_LO, TRAIL_MID))
                                               : 8'($urandom_range(TRAIL_UP, LEAD_HI)));
      end else if (kind < 75) begin
         text_q.push_back(lead_byte());
         text_q.push_back(digit_byte());
         text_q.push_back(lead_byte());
         text_q.push_back(digit_byte());
      end else if (kind < 83) begin
         text_q.push_back(lead_byte());
         if ($urandom_range(0, 1)) begin
            text_q.push_back(digit_byte());
         end
         text_q.push_back(8'($urandom_range(0, 255)));
      end else if (kind < 88) begin
         text_q.push_back(NUL_BYTE);
      end else begin
         text_q.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int                   phase;
      int                   sent;
      int                   k;
      int                   len;
      logic                 paused;
      logic [PAT_WIDTH-1:0] pat;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: words, both character forms, broken and cut sequences,
      // ignored bytes, NUL, and a text ending on a NUL
      set_idling(IDLE_NONE);
      write_reg(ADDR_PATTERN, 64'h6261);  // "ab"
      write_reg(ADDR_LENGTH, 64'd2);
      text_q = '{8'h61, 8'h62, 8'h61, 8'h62, SPACE_BYTE, TAB_BYTE,
                 LEAD_LO, TRAIL_LO, LEAD_LO, DIGIT_LO, LEAD_HI, DIGIT_HI,
                 LEAD_LO, DIGIT_LO, LINE_FEED, LEAD_HI, SPACE_BYTE,
                 8'h7F, 8'h80, 8'hFF, NUL_BYTE, 8'h01, 8'h78, LINE_FEED, NUL_BYTE};
      send_text();
      drain();
      // Pattern running across the line feed
      write_reg(ADDR_PATTERN, 64'h0A78);  // "x\n"
      text_q = '{8'h78, LINE_FEED, LEAD_HI};
      send_text();

      // Random phases, each with its own pattern and idling
      paused = 1'b0;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain();
         set_idling(idle_mode_type'(phase % 4));
         if (phase == 0) begin
            pat = 64'h61;
            len = 1;
         end else if (phase == 1) begin
            pat = '1;
            len = 15;  // above the maximum, acts as eight
         end else if (phase == 2) begin
            pat = '0;
            len = 0;   // acts as one; a zero byte never matches
         end else begin
            for (k = 0; k < PATTERN_MAX; k++) begin
               pat[8*k +: 8] = pattern_byte();
            end
            len = (phase == RANDOM_PHASES - 1) ? PATTERN_MAX :
                  $urandom_range(0, 1) ? $urandom_range(1, 3) : $urandom_range(1, PATTERN_MAX);
         end
         write_reg(ADDR_PATTERN, pat);
         write_reg(ADDR_LENGTH, PAT_WIDTH'(len));
         if (phase == 0) begin
            want_hold <= 1'b1;  // receiver backs up while bytes keep coming
         end
         sent = 0;
         while (sent < BYTES_PER_PHASE) begin
            n_tokens_text();
            sent += text_q.size();
            send_text();
            if (phase == 5 && !paused && sent >= BYTES_PER_PHASE / 2) begin
               drain();
               paused = 1'b1;
            end
         end
      end

      drain();
      if (error_count == 0 && pending_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Build one text: mostly a few tokens, now and then a long one
   task automatic n_tokens_text();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
      repeat (n) add_token();
   endtask

endmodule
